/* hw/rtl/lrs_pkg.sv */
package lrs_pkg;

  localparam int MAX_POP_DEF = 64;
  localparam int PS_W        = 7;
  localparam int FIT_W       = 32;
  localparam int DRAW_W      = 16;
  localparam int OUT_W       = 6;
  localparam int ST_W        = 2;

  localparam logic [PS_W-1:0] POP_SIZE_RESET = 7'd16;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SELECT = 1'b1;

  localparam logic [ST_W-1:0] ST_OK         = 2'd0;
  localparam logic [ST_W-1:0] ST_INCOMPLETE = 2'd1;
  localparam logic [ST_W-1:0] ST_DROPPED    = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_SHIFT,
    S_PLACE,
    S_PREP,
    S_MUL,
    S_WALK,
    S_FETCH,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic decide;
    logic scan;
    logic shift;
    logic place;
    logic prep;
    logic mul;
    logic walk;
    logic fetch;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_select;
    logic full;
    logic scan_done;
    logic shift_done;
    logic walk_done;
    logic out_free;
  } sts_t;

  // Flipping the sign bit gives an unsigned key ordered like the signed value.
  function automatic logic [FIT_W-1:0] order_key(input logic [FIT_W-1:0] v);
    return {~v[FIT_W-1], v[FIT_W-2:0]};
  endfunction

endpackage

/* hw/rtl/lrs_in_if.sv */
interface lrs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 func;
  logic                                 first;
  logic signed [lrs_pkg::FIT_W-1:0]     fitness;
  logic        [lrs_pkg::DRAW_W-1:0]    draw;

  modport source (output valid, func, first, fitness, draw, input ready);
  modport sink   (input valid, func, first, fitness, draw, output ready);
endinterface

/* hw/rtl/lrs_out_if.sv */
interface lrs_out_if;
  logic                          valid;
  logic                          ready;
  logic [lrs_pkg::OUT_W-1:0]     chosen_index;
  logic [lrs_pkg::OUT_W-1:0]     chosen_rank;
  logic [lrs_pkg::ST_W-1:0]      status;

  modport source (output valid, chosen_index, chosen_rank, status, input ready);
  modport sink   (input valid, chosen_index, chosen_rank, status, output ready);
endinterface

/* hw/rtl/lrs_cfg_if.sv */
interface lrs_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lrs_pkg::PS_W-1:0]   pop_size;

  modport source (output valid, pop_size, input ready);
  modport sink   (input valid, pop_size, output ready);
endinterface

/* hw/rtl/lrs_ram.sv */
module lrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/lrs_ctrl.sv */
module lrs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lrs_pkg::sts_t sts,
  output lrs_pkg::cmd_t cmd
);

  lrs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lrs_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = lrs_pkg::S_DECIDE;
        end
      end
      lrs_pkg::S_DECIDE: begin
        if (sts.is_select) begin
          state_nxt = sts.full ? lrs_pkg::S_PREP : lrs_pkg::S_FINISH;
        end else begin
          state_nxt = sts.full ? lrs_pkg::S_FINISH : lrs_pkg::S_SCAN;
        end
      end
      lrs_pkg::S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = lrs_pkg::S_SHIFT;
        end
      end
      lrs_pkg::S_SHIFT: begin
        if (sts.shift_done) begin
          state_nxt = lrs_pkg::S_PLACE;
        end
      end
      lrs_pkg::S_PLACE: state_nxt = lrs_pkg::S_FINISH;
      lrs_pkg::S_PREP:  state_nxt = lrs_pkg::S_MUL;
      lrs_pkg::S_MUL:   state_nxt = lrs_pkg::S_WALK;
      lrs_pkg::S_WALK: begin
        if (sts.walk_done) begin
          state_nxt = lrs_pkg::S_FETCH;
        end
      end
      lrs_pkg::S_FETCH: state_nxt = lrs_pkg::S_FINISH;
      lrs_pkg::S_FINISH: begin
        if (sts.out_free) begin
          state_nxt = lrs_pkg::S_IDLE;
        end
      end
      default: state_nxt = lrs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      lrs_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      lrs_pkg::S_DECIDE: cmd.decide = 1'b1;
      lrs_pkg::S_SCAN:   cmd.scan   = 1'b1;
      lrs_pkg::S_SHIFT:  cmd.shift  = 1'b1;
      lrs_pkg::S_PLACE:  cmd.place  = 1'b1;
      lrs_pkg::S_PREP:   cmd.prep   = 1'b1;
      lrs_pkg::S_MUL:    cmd.mul    = 1'b1;
      lrs_pkg::S_WALK:   cmd.walk   = 1'b1;
      lrs_pkg::S_FETCH:  cmd.fetch  = 1'b1;
      lrs_pkg::S_FINISH: cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

/* hw/rtl/lrs_dp.sv */
module lrs_dp #(
  parameter int MAX_POP = lrs_pkg::MAX_POP_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lrs_pkg::cmd_t                      cmd,
  output lrs_pkg::sts_t                      sts,
  input  logic                               in_func,
  input  logic                               in_first,
  input  logic signed [lrs_pkg::FIT_W-1:0]   in_fitness,
  input  logic        [lrs_pkg::DRAW_W-1:0]  in_draw,
  input  logic                               cfg_valid,
  input  logic        [lrs_pkg::PS_W-1:0]    cfg_pop_size,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic        [lrs_pkg::OUT_W-1:0]   out_chosen_index,
  output logic        [lrs_pkg::OUT_W-1:0]   out_chosen_rank,
  output logic        [lrs_pkg::ST_W-1:0]    out_status
);

  localparam int CW = $clog2(MAX_POP + 1);
  localparam int IW = $clog2(MAX_POP);
  localparam int SW = 2 * CW;
  localparam int TW = lrs_pkg::DRAW_W + SW;
  localparam int EW = (CW > lrs_pkg::PS_W) ? CW : lrs_pkg::PS_W;
  localparam logic [EW-1:0] MAX_E = EW'(MAX_POP);
  localparam logic [EW-1:0] MIN_E = EW'(2);

  logic [lrs_pkg::PS_W-1:0]  pop_size_r, pop_size_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic                      func_r, func_nxt;
  logic [lrs_pkg::FIT_W-1:0] fit_r, fit_nxt;
  logic [lrs_pkg::DRAW_W-1:0] draw_r, draw_nxt;
  logic [CW-1:0]             j_r, j_nxt;
  logic [CW-1:0]             pos_r, pos_nxt;
  logic                      scan_v_r, scan_v_nxt;
  logic                      pend_v_r, pend_v_nxt;
  logic [IW-1:0]             pend_addr_r, pend_addr_nxt;
  logic [SW-1:0]             s_r, s_nxt;
  logic [TW-1:0]             target_r, target_nxt;
  logic [SW-1:0]             cum_r, cum_nxt;
  logic [CW-1:0]             r_r, r_nxt;
  logic [lrs_pkg::ST_W-1:0]  res_st_r, res_st_nxt;
  logic [lrs_pkg::OUT_W-1:0] res_idx_r, res_idx_nxt;
  logic [lrs_pkg::OUT_W-1:0] res_rank_r, res_rank_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [lrs_pkg::ST_W-1:0]  out_st_r, out_st_nxt;
  logic [lrs_pkg::OUT_W-1:0] out_idx_r, out_idx_nxt;
  logic [lrs_pkg::OUT_W-1:0] out_rank_r, out_rank_nxt;

  logic [EW-1:0]             ps_ext;
  logic [CW-1:0]             n_eff;
  logic                      full;
  logic                      scan_go;
  logic                      shift_go;
  logic                      walk_last;
  logic                      walk_hit;
  logic [CW-1:0]             j_dec;
  logic [SW-1:0]             prod_s;
  logic [TW-1:0]             prod_t;

  logic                      fit_we, fit_re;
  logic [IW-1:0]             fit_waddr, fit_raddr;
  logic [lrs_pkg::FIT_W-1:0] fit_wdata, fit_rdata;
  logic                      rk_we, rk_re;
  logic [IW-1:0]             rk_waddr, rk_raddr;
  logic [IW-1:0]             rk_wdata, rk_rdata;

  lrs_ram #(.WIDTH(lrs_pkg::FIT_W), .DEPTH(MAX_POP)) u_fit_ram (
    .clk   (clk),
    .we    (fit_we),
    .waddr (fit_waddr),
    .wdata (fit_wdata),
    .re    (fit_re),
    .raddr (fit_raddr),
    .rdata (fit_rdata)
  );

  lrs_ram #(.WIDTH(IW), .DEPTH(MAX_POP)) u_rank_ram (
    .clk   (clk),
    .we    (rk_we),
    .waddr (rk_waddr),
    .wdata (rk_wdata),
    .re    (rk_re),
    .raddr (rk_raddr),
    .rdata (rk_rdata)
  );

  always_comb begin
    ps_ext = EW'(pop_size_r);
    priority if (ps_ext < MIN_E) begin
      n_eff = CW'(MIN_E);
    end else if (ps_ext > MAX_E) begin
      n_eff = CW'(MAX_E);
    end else begin
      n_eff = CW'(ps_ext);
    end
  end

  assign full      = (cnt_r >= n_eff);
  assign scan_go   = (j_r < cnt_r);
  assign shift_go  = (j_r > pos_r);
  assign j_dec     = j_r - CW'(1);
  assign walk_last = (({1'b0, r_r} + (CW + 1)'(1)) >= {1'b0, n_eff});
  assign walk_hit  = ({cum_r, {lrs_pkg::DRAW_W{1'b0}}} > target_r);
  assign prod_s    = SW'(n_eff) * (SW'(n_eff) + SW'(1));
  assign prod_t    = TW'(draw_r) * TW'(s_r);

  always_comb begin
    sts.is_select  = (func_r == lrs_pkg::FUNC_SELECT);
    sts.full       = full;
    sts.scan_done  = !scan_go && !scan_v_r;
    sts.shift_done = !shift_go && !pend_v_r;
    sts.walk_done  = walk_last || walk_hit;
    sts.out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    pop_size_nxt  = pop_size_r;
    cnt_nxt       = cnt_r;
    func_nxt      = func_r;
    fit_nxt       = fit_r;
    draw_nxt      = draw_r;
    j_nxt         = j_r;
    pos_nxt       = pos_r;
    scan_v_nxt    = scan_v_r;
    pend_v_nxt    = pend_v_r;
    pend_addr_nxt = pend_addr_r;
    s_nxt         = s_r;
    target_nxt    = target_r;
    cum_nxt       = cum_r;
    r_nxt         = r_r;
    res_st_nxt    = res_st_r;
    res_idx_nxt   = res_idx_r;
    res_rank_nxt  = res_rank_r;
    out_valid_nxt = out_valid_r;
    out_st_nxt    = out_st_r;
    out_idx_nxt   = out_idx_r;
    out_rank_nxt  = out_rank_r;

    fit_we    = 1'b0;
    fit_waddr = cnt_r[IW-1:0];
    fit_wdata = fit_r;
    fit_re    = 1'b0;
    fit_raddr = j_r[IW-1:0];
    rk_we     = 1'b0;
    rk_waddr  = pend_addr_r;
    rk_wdata  = rk_rdata;
    rk_re     = 1'b0;
    rk_raddr  = r_r[IW-1:0];

    if (cfg_valid) begin
      pop_size_nxt = cfg_pop_size;
      cnt_nxt      = '0;
    end

    if (cmd.accept) begin
      func_nxt = in_func;
      fit_nxt  = in_fitness;
      draw_nxt = in_draw;
      if ((in_func == lrs_pkg::FUNC_LOAD) && in_first) begin
        cnt_nxt = '0;
      end
    end

    if (cmd.decide) begin
      j_nxt        = '0;
      pos_nxt      = '0;
      scan_v_nxt   = 1'b0;
      pend_v_nxt   = 1'b0;
      res_idx_nxt  = '0;
      res_rank_nxt = '0;
      if (func_r == lrs_pkg::FUNC_LOAD) begin
        res_st_nxt = full ? lrs_pkg::ST_DROPPED : lrs_pkg::ST_OK;
      end else begin
        res_st_nxt = full ? lrs_pkg::ST_OK : lrs_pkg::ST_INCOMPLETE;
      end
    end

    if (cmd.scan) begin
      scan_v_nxt = scan_go;
      if (scan_go) begin
        fit_re = 1'b1;
        j_nxt  = j_r + CW'(1);
      end
      if (scan_v_r &&
          (lrs_pkg::order_key(fit_rdata) >= lrs_pkg::order_key(fit_r))) begin
        pos_nxt = pos_r + CW'(1);
      end
      if (!scan_go && !scan_v_r) begin
        j_nxt = cnt_r;
      end
    end

    if (cmd.shift) begin
      pend_v_nxt = shift_go;
      if (shift_go) begin
        rk_re         = 1'b1;
        rk_raddr      = j_dec[IW-1:0];
        pend_addr_nxt = j_r[IW-1:0];
        j_nxt         = j_dec;
      end
      if (pend_v_r) begin
        rk_we = 1'b1;
      end
    end

    if (cmd.place) begin
      fit_we   = 1'b1;
      rk_we    = 1'b1;
      rk_waddr = pos_r[IW-1:0];
      rk_wdata = cnt_r[IW-1:0];
      cnt_nxt  = cnt_r + CW'(1);
    end

    if (cmd.prep) begin
      s_nxt   = prod_s >> 1;
      cum_nxt = SW'(n_eff);
      r_nxt   = '0;
    end

    if (cmd.mul) begin
      target_nxt = prod_t;
    end

    if (cmd.walk) begin
      if (walk_last || walk_hit) begin
        rk_re    = 1'b1;
        rk_raddr = r_r[IW-1:0];
      end else begin
        r_nxt   = r_r + CW'(1);
        cum_nxt = cum_r + SW'(n_eff - r_r - CW'(1));
      end
    end

    if (cmd.fetch) begin
      res_idx_nxt  = lrs_pkg::OUT_W'(rk_rdata);
      res_rank_nxt = lrs_pkg::OUT_W'(r_r);
    end

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_st_nxt    = res_st_r;
      out_idx_nxt   = res_idx_r;
      out_rank_nxt  = res_rank_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_size_r  <= lrs_pkg::POP_SIZE_RESET;
      cnt_r       <= '0;
      scan_v_r    <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pop_size_r  <= pop_size_nxt;
      cnt_r       <= cnt_nxt;
      scan_v_r    <= scan_v_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    fit_r       <= fit_nxt;
    draw_r      <= draw_nxt;
    j_r         <= j_nxt;
    pos_r       <= pos_nxt;
    pend_addr_r <= pend_addr_nxt;
    s_r         <= s_nxt;
    target_r    <= target_nxt;
    cum_r       <= cum_nxt;
    r_r         <= r_nxt;
    res_st_r    <= res_st_nxt;
    res_idx_r   <= res_idx_nxt;
    res_rank_r  <= res_rank_nxt;
    out_st_r    <= out_st_nxt;
    out_idx_r   <= out_idx_nxt;
    out_rank_r  <= out_rank_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_chosen_index = out_idx_r;
  assign out_chosen_rank  = out_rank_r;
  assign out_status       = out_st_r;

endmodule

/* hw/rtl/linear_rank_selection.sv */
// Channel  Direction  Beat contents
// in_ch    sink       func, first, fitness, draw
// out_ch   source     chosen_index, chosen_rank, status
// cfg_ch   sink       pop_size
//
// A load makes one pass over the fitness memory, which counts the entries at least as good as
// the new value, and a second pass over the rank memory, which opens the slot.
// A selection walks over the cumulative rank weights.
// Reset is synchronous; the stores hold nothing valid until loaded, and the count clears.
// A new beat is taken while the previous result still waits in the output register.
module linear_rank_selection #(
  parameter int MAX_POP = lrs_pkg::MAX_POP_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  lrs_in_if.sink    in_ch,
  lrs_out_if.source out_ch,
  lrs_cfg_if.sink   cfg_ch
);

  lrs_pkg::cmd_t cmd;
  lrs_pkg::sts_t sts;
  logic          in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  lrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lrs_dp #(.MAX_POP(MAX_POP)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_func          (in_ch.func),
    .in_first         (in_ch.first),
    .in_fitness       (in_ch.fitness),
    .in_draw          (in_ch.draw),
    .cfg_valid        (cfg_ch.valid),
    .cfg_pop_size     (cfg_ch.pop_size),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_chosen_index (out_ch.chosen_index),
    .out_chosen_rank  (out_ch.chosen_rank),
    .out_status       (out_ch.status)
  );

endmodule
